### rtl/fcp_pkg.sv
// Shared types and constants for the friction cone projection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package fcp_pkg;

    // Widths of the intermediate results
    localparam int NP_W  = 36;  // projected normal before saturation
    localparam int K_W   = 54;  // mu * n'
    localparam int TQ_W  = 39;  // scaled tangent magnitude
    localparam int A_W   = 51;  // positive numerator of the normal projection
    localparam int D_W   = 37;  // mu^2 + 1 in Q.32
    localparam int TN_W  = 88;  // tangent dividend

    // Region codes of a result beat
    typedef enum logic [1:0] {
        REG_POLAR  = 2'd0,
        REG_INSIDE = 2'd1,
        REG_PROJ   = 2'd2
    } t_region;

    // Context that travels with each beat down the pipeline
    typedef struct packed {
        logic [31:0]     n;
        logic [31:0]     ta;
        logic [31:0]     tb;
        logic [17:0]     mu;
        logic [31:0]     nt;
        t_region         region;
        logic [NP_W-1:0] np;
        logic [TQ_W-1:0] qa;
        logic [TQ_W-1:0] qb;
    } t_item;

endpackage
`default_nettype wire

### rtl/fcp_prep.sv
// Front stages: tangent magnitudes, squares and the radicand of the norm.
`timescale 1ns / 1ps
`default_nettype none
module fcp_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire fcp_pkg::t_item i_item,
    output logic               o_valid,
    output fcp_pkg::t_item     o_item,
    output logic [63:0]        o_rad
);
    logic           r_v1, r_v2, r_v3;
    fcp_pkg::t_item r_it1, r_it2, r_it3;
    logic [31:0]    r_ma, r_mb;
    logic [63:0]    r_sqa, r_sqb, r_rad;
    logic [31:0]    n_ma, n_mb;

    // Take magnitudes of the tangents
    always_comb begin
        n_ma = i_item.ta[31] ? (~i_item.ta + 32'd1) : i_item.ta;
        n_mb = i_item.tb[31] ? (~i_item.tb + 32'd1) : i_item.tb;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Square, then sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it1 <= i_item;
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_it2 <= r_it1;
            r_sqa <= r_ma * r_ma;
            r_sqb <= r_mb * r_mb;
            r_it3 <= r_it2;
            r_rad <= r_sqa + r_sqb;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_it3;
    assign o_rad   = r_rad;
endmodule
`default_nettype wire

### rtl/fcp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module fcp_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire fcp_pkg::t_item i_item,
    input  wire logic [63:0]   i_rad,
    output logic               o_valid,
    output fcp_pkg::t_item     o_item
);
    logic           w_v   [0:32];
    fcp_pkg::t_item w_it  [0:32];
    logic [63:0]    w_rem [0:32];
    logic [63:0]    w_res [0:32];

    assign w_v[0]   = i_valid;
    assign w_it[0]  = i_item;
    assign w_rem[0] = i_rad;
    assign w_res[0] = 64'd0;

    for (genvar g = 0; g < 32; g++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic           r_v;
        fcp_pkg::t_item r_it;
        logic [63:0]    r_rem, r_res;
        logic [63:0]    n_rem, n_res, w_trial;

        // Try the next root bit
        always_comb begin
            w_trial = w_res[g] + BIT;
            if (w_rem[g] >= w_trial) begin
                n_rem = w_rem[g] - w_trial;
                n_res = (w_res[g] >> 1) + BIT;
            end else begin
                n_rem = w_rem[g];
                n_res = w_res[g] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_it  <= w_it[g];
                r_rem <= n_rem;
                r_res <= n_res;
            end
        end

        assign w_v[g+1]   = r_v;
        assign w_it[g+1]  = r_it;
        assign w_rem[g+1] = r_rem;
        assign w_res[g+1] = r_res;
    end

    // Attach the norm to the beat
    always_comb begin
        o_item    = w_it[32];
        o_item.nt = w_res[32][31:0];
    end
    assign o_valid = w_v[32];
endmodule
`default_nettype wire

### rtl/fcp_class.sv
// Cone tests and the operands of the normal projection.
`timescale 1ns / 1ps
`default_nettype none
module fcp_class (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire fcp_pkg::t_item           i_item,
    output logic                          o_valid,
    output fcp_pkg::t_item                o_item,
    output logic [fcp_pkg::A_W-1:0]       o_a,
    output logic [fcp_pkg::D_W-1:0]       o_d
);
    logic                      r_v1, r_v2;
    fcp_pkg::t_item            r_it1, r_it2;
    logic [49:0]               r_munt;
    logic signed [50:0]        r_mun;
    logic [fcp_pkg::D_W-1:0]   r_d1, r_d2;
    logic [fcp_pkg::A_W-1:0]   r_a;
    logic signed [51:0]        w_a;
    logic                      w_polar, w_inside;
    fcp_pkg::t_item            n_it2;

    // Compare against the cone and its polar
    always_comb begin
        w_a      = $signed({2'b00, r_munt}) + $signed({{4{r_it1.n[31]}}, r_it1.n, 16'd0});
        w_polar  = (w_a <= 52'sd0);
        w_inside = ($signed({3'b000, r_it1.nt, 16'd0}) <= r_mun);
        n_it2    = r_it1;
        priority if (w_polar) begin
            n_it2.region = fcp_pkg::REG_POLAR;
        end else if (w_inside) begin
            n_it2.region = fcp_pkg::REG_INSIDE;
        end else begin
            n_it2.region = fcp_pkg::REG_PROJ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Form products, then the tests
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it1  <= i_item;
            r_munt <= i_item.mu * i_item.nt;
            r_mun  <= $signed({1'b0, i_item.mu}) * $signed(i_item.n);
            r_d1   <= 37'(i_item.mu) * 37'(i_item.mu) + 37'h1_0000_0000;
            r_it2  <= n_it2;
            r_a    <= w_a[fcp_pkg::A_W-1:0];
            r_d2   <= r_d1;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_it2;
    assign o_a     = r_a;
    assign o_d     = r_d2;
endmodule
`default_nettype wire

### rtl/fcp_ndiv.sv
// Pipelined restoring divider for the rounded projected normal.
`timescale 1ns / 1ps
`default_nettype none
module fcp_ndiv (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire fcp_pkg::t_item              i_item,
    input  wire logic [fcp_pkg::A_W-1:0]     i_a,
    input  wire logic [fcp_pkg::D_W-1:0]     i_d,
    output logic                             o_valid,
    output fcp_pkg::t_item                   o_item
);
    localparam int RW = 74;
    localparam int NQ = fcp_pkg::NP_W;

    logic            w_v   [0:NQ];
    fcp_pkg::t_item  w_it  [0:NQ];
    logic [RW-1:0]   w_rem [0:NQ];
    logic [37:0]     w_den [0:NQ];
    logic [NQ-1:0]   w_q   [0:NQ];

    // Dividend 2a*2^16 + d over divisor 2d rounds half away from zero
    assign w_v[0]   = i_valid;
    assign w_it[0]  = i_item;
    assign w_rem[0] = RW'({i_a, 17'd0}) + RW'(i_d);
    assign w_den[0] = {i_d, 1'b0};
    assign w_q[0]   = '0;

    for (genvar g = 0; g < NQ; g++) begin : g_stage
        localparam int SH = NQ - 1 - g;
        logic            r_v;
        fcp_pkg::t_item  r_it;
        logic [RW-1:0]   r_rem;
        logic [37:0]     r_den;
        logic [NQ-1:0]   r_q;
        logic [RW-1:0]   w_sub;
        logic            w_ge;

        assign w_sub = RW'(w_den[g]) << SH;
        assign w_ge  = (w_rem[g] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        // Subtract where it fits and shift in the quotient bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_it  <= w_it[g];
                r_den <= w_den[g];
                r_rem <= w_ge ? (w_rem[g] - w_sub) : w_rem[g];
                r_q   <= {w_q[g][NQ-2:0], w_ge};
            end
        end

        assign w_v[g+1]   = r_v;
        assign w_it[g+1]  = r_it;
        assign w_rem[g+1] = r_rem;
        assign w_den[g+1] = r_den;
        assign w_q[g+1]   = r_q;
    end

    always_comb begin
        o_item    = w_it[NQ];
        o_item.np = w_q[NQ];
    end
    assign o_valid = w_v[NQ];
endmodule
`default_nettype wire

### rtl/fcp_scale.sv
// Tangent dividends: k = mu*n', then k*|t| plus the rounding half of the divisor.
`timescale 1ns / 1ps
`default_nettype none
module fcp_scale (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire fcp_pkg::t_item           i_item,
    output logic                          o_valid,
    output fcp_pkg::t_item                o_item,
    output logic [fcp_pkg::TN_W-1:0]      o_na,
    output logic [fcp_pkg::TN_W-1:0]      o_nb
);
    localparam int TW = fcp_pkg::TN_W;

    logic                       r_v1, r_v2, r_v3;
    fcp_pkg::t_item             r_it1, r_it2, r_it3;
    logic [fcp_pkg::K_W-1:0]    r_k;
    logic [31:0]                r_ma, r_mb;
    logic [58:0]                r_pal, r_pah, r_pbl, r_pbh;
    logic [TW-1:0]              r_na, r_nb;
    logic [31:0]                n_ma, n_mb;

    always_comb begin
        n_ma = i_item.ta[31] ? (~i_item.ta + 32'd1) : i_item.ta;
        n_mb = i_item.tb[31] ? (~i_item.tb + 32'd1) : i_item.tb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Multiply k, split k for the tangent products, then sum the halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it1 <= i_item;
            r_k   <= i_item.mu * i_item.np;
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_it2 <= r_it1;
            r_pal <= r_k[26:0] * r_ma;
            r_pah <= r_k[53:27] * r_ma;
            r_pbl <= r_k[26:0] * r_mb;
            r_pbh <= r_k[53:27] * r_mb;
            r_it3 <= r_it2;
            r_na  <= (TW'(r_pah) << 27) + TW'(r_pal) + (TW'(r_it2.nt) << 15);
            r_nb  <= (TW'(r_pbh) << 27) + TW'(r_pbl) + (TW'(r_it2.nt) << 15);
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_it3;
    assign o_na    = r_na;
    assign o_nb    = r_nb;
endmodule
`default_nettype wire

### rtl/fcp_tdiv.sv
// Two-lane pipelined restoring divider for the scaled tangent magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module fcp_tdiv (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire fcp_pkg::t_item           i_item,
    input  wire logic [fcp_pkg::TN_W-1:0] i_na,
    input  wire logic [fcp_pkg::TN_W-1:0] i_nb,
    output logic                          o_valid,
    output fcp_pkg::t_item                o_item
);
    localparam int TW = fcp_pkg::TN_W;
    localparam int NQ = fcp_pkg::TQ_W;

    logic            w_v  [0:NQ];
    fcp_pkg::t_item  w_it [0:NQ];
    logic [TW-1:0]   w_ra [0:NQ];
    logic [TW-1:0]   w_rb [0:NQ];
    logic [NQ-1:0]   w_qa [0:NQ];
    logic [NQ-1:0]   w_qb [0:NQ];

    assign w_v[0]  = i_valid;
    assign w_it[0] = i_item;
    assign w_ra[0] = i_na;
    assign w_rb[0] = i_nb;
    assign w_qa[0] = '0;
    assign w_qb[0] = '0;

    for (genvar g = 0; g < NQ; g++) begin : g_stage
        localparam int SH = NQ - 1 - g;
        logic            r_v;
        fcp_pkg::t_item  r_it;
        logic [TW-1:0]   r_ra, r_rb;
        logic [NQ-1:0]   r_qa, r_qb;
        logic [TW-1:0]   w_sub;
        logic            w_gea, w_geb;

        // Divisor is the tangent norm nt * 2^16, shifted to this quotient bit
        assign w_sub = TW'(w_it[g].nt) << (16 + SH);
        assign w_gea = (w_ra[g] >= w_sub);
        assign w_geb = (w_rb[g] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_it <= w_it[g];
                r_ra <= w_gea ? (w_ra[g] - w_sub) : w_ra[g];
                r_rb <= w_geb ? (w_rb[g] - w_sub) : w_rb[g];
                r_qa <= {w_qa[g][NQ-2:0], w_gea};
                r_qb <= {w_qb[g][NQ-2:0], w_geb};
            end
        end

        assign w_v[g+1]  = r_v;
        assign w_it[g+1] = r_it;
        assign w_ra[g+1] = r_ra;
        assign w_rb[g+1] = r_rb;
        assign w_qa[g+1] = r_qa;
        assign w_qb[g+1] = r_qb;
    end

    always_comb begin
        o_item    = w_it[NQ];
        o_item.qa = w_qa[NQ];
        o_item.qb = w_qb[NQ];
    end
    assign o_valid = w_v[NQ];
endmodule
`default_nettype wire

### rtl/friction_cone_projection_core.sv
// Beats pass through prep, sqrt, class, ndiv, scale, tdiv and an output register.
// Throughput: one beat per cycle; a stalled output beat freezes the whole pipeline.
// Depth is set by the 32-stage square root and the 36- and 39-stage dividers.
// Reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module friction_cone_projection_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_normal_in,
    input  wire logic [31:0] i_tangent_a_in,
    input  wire logic [31:0] i_tangent_b_in,
    input  wire logic [17:0] i_friction_coeff,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_normal_out,
    output logic [31:0]      o_tangent_a_out,
    output logic [31:0]      o_tangent_b_out,
    output logic [1:0]       o_region
);
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    logic                          w_en;
    fcp_pkg::t_item                w_in_item;
    logic                          w_pv, w_sv, w_cv, w_nv, w_kv, w_tv;
    fcp_pkg::t_item                w_pit, w_sit, w_cit, w_nit, w_kit, w_tit;
    logic [63:0]                   w_rad;
    logic [fcp_pkg::A_W-1:0]       w_a;
    logic [fcp_pkg::D_W-1:0]       w_d;
    logic [fcp_pkg::TN_W-1:0]      w_na, w_nb;
    logic                          r_out_valid;
    logic [31:0]                   r_n, r_ta, r_tb;
    logic [1:0]                    r_region;
    logic [31:0]                   n_n, n_ta, n_tb, w_pn, w_pa, w_pb;

    // Hold every stage while the output beat waits
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    always_comb begin
        w_in_item        = '0;
        w_in_item.n      = i_normal_in;
        w_in_item.ta     = i_tangent_a_in;
        w_in_item.tb     = i_tangent_b_in;
        w_in_item.mu     = i_friction_coeff;
        w_in_item.region = fcp_pkg::REG_POLAR;
    end

    fcp_prep u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_valid), .i_item(w_in_item),
        .o_valid(w_pv), .o_item(w_pit), .o_rad(w_rad)
    );

    fcp_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_pv), .i_item(w_pit), .i_rad(w_rad),
        .o_valid(w_sv), .o_item(w_sit)
    );

    fcp_class u_class (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_sv), .i_item(w_sit),
        .o_valid(w_cv), .o_item(w_cit), .o_a(w_a), .o_d(w_d)
    );

    fcp_ndiv u_ndiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_cv), .i_item(w_cit), .i_a(w_a), .i_d(w_d),
        .o_valid(w_nv), .o_item(w_nit)
    );

    fcp_scale u_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_nv), .i_item(w_nit),
        .o_valid(w_kv), .o_item(w_kit), .o_na(w_na), .o_nb(w_nb)
    );

    fcp_tdiv u_tdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_kv), .i_item(w_kit), .i_na(w_na), .i_nb(w_nb),
        .o_valid(w_tv), .o_item(w_tit)
    );

    // Saturate the projected components and restore tangent signs
    always_comb begin
        w_pn = (w_tit.np > fcp_pkg::NP_W'(S32_MAX)) ? S32_MAX : w_tit.np[31:0];
        if (w_tit.ta[31]) begin
            w_pa = (w_tit.qa >= fcp_pkg::TQ_W'(S32_MIN)) ? S32_MIN
                                                        : (~w_tit.qa[31:0] + 32'd1);
        end else begin
            w_pa = (w_tit.qa > fcp_pkg::TQ_W'(S32_MAX)) ? S32_MAX : w_tit.qa[31:0];
        end
        if (w_tit.tb[31]) begin
            w_pb = (w_tit.qb >= fcp_pkg::TQ_W'(S32_MIN)) ? S32_MIN
                                                        : (~w_tit.qb[31:0] + 32'd1);
        end else begin
            w_pb = (w_tit.qb > fcp_pkg::TQ_W'(S32_MAX)) ? S32_MAX : w_tit.qb[31:0];
        end
    end

    // Select the result by region
    always_comb begin
        unique case (w_tit.region)
            fcp_pkg::REG_INSIDE: begin
                n_n  = w_tit.n;
                n_ta = w_tit.ta;
                n_tb = w_tit.tb;
            end
            fcp_pkg::REG_PROJ: begin
                n_n  = w_pn;
                n_ta = w_pa;
                n_tb = w_pb;
            end
            default: begin
                n_n  = 32'd0;
                n_ta = 32'd0;
                n_tb = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n      <= n_n;
            r_ta     <= n_ta;
            r_tb     <= n_tb;
            r_region <= w_tit.region;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_normal_out    = r_n;
    assign o_tangent_a_out = r_ta;
    assign o_tangent_b_out = r_tb;
    assign o_region        = r_region;
endmodule
`default_nettype wire
